// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hoc_pkg.sv
// Types, constants and offer byte functions for the handshake offer checker.
`default_nettype none

package hoc_pkg;

    localparam int COUNT_BITS = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [4:0]            rx_idx_t;

    localparam rx_idx_t IDX_WORDS   = 5'd4;
    localparam rx_idx_t IDX_PLAYERS = 5'd24;
    localparam rx_idx_t IDX_SLOT    = 5'd25;
    localparam rx_idx_t IDX_LAST    = 5'd27;
    localparam rx_idx_t OFFER_LEN   = 5'd28;
    localparam rx_idx_t RX_SAT      = 5'd29;

    localparam logic [7:0] GRACE_RESET   = 8'd4;
    localparam logic [7:0] PLAYERS_RESET = 8'd2;

    localparam logic [7:0] TAG_B0 = 8'h43;
    localparam logic [7:0] TAG_B1 = 8'h53;
    localparam logic [7:0] TAG_B2 = 8'h45;
    localparam logic [7:0] TAG_B3 = 8'h48;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_OFFER   = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_AGREED  = 2'd1,
        PH_REFUSED = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        RSN_NONE       = 4'd0,
        RSN_PROTOCOL   = 4'd1,
        RSN_PLAYERS    = 4'd2,
        RSN_STATE_SIZE = 4'd3,
        RSN_INPUT_SIZE = 4'd4,
        RSN_SEED       = 4'd5,
        RSN_HASH       = 4'd6,
        RSN_SAME_SLOT  = 4'd7,
        RSN_SLOT_RANGE = 4'd8
    } reason_t;

    typedef enum logic [2:0] {
        REG_PROTOCOL     = 3'd0,
        REG_HASH         = 3'd1,
        REG_STATE_SIZE   = 3'd2,
        REG_INPUT_SIZE   = 3'd3,
        REG_SEED         = 3'd4,
        REG_PLAYER_COUNT = 3'd5,
        REG_SLOT         = 3'd6,
        REG_GRACE        = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [4:0][31:0] word;        // protocol, hash, state size, input size, seed
        logic [7:0]       player_count;
        logic [7:0]       slot;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic [7:0] value;
    } grace_wr_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
        logic       rx_last;
        logic       from_peer;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        consumed;
        phase_t      phase;
        reason_t     reason;
        logic [15:0] sent;
        logic [15:0] fwd;
    } beat_t;

    function automatic logic [7:0] tag_byte(input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = TAG_B0;
            2'd1:    b = TAG_B1;
            2'd2:    b = TAG_B2;
            default: b = TAG_B3;
        endcase
        return b;
    endfunction

    // word index -> mismatch flag bit (flag bit k is reason k+1)
    function automatic logic [2:0] word_flag(input logic [2:0] w);
        logic [2:0] f;
        case (w)
            3'd0:    f = 3'd0;
            3'd1:    f = 3'd5;
            3'd2:    f = 3'd2;
            3'd3:    f = 3'd3;
            3'd4:    f = 3'd4;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [7:0] offer_byte(input cfg_t c, input rx_idx_t i);
        rx_idx_t    wi;
        logic [7:0] b;
        wi = i - IDX_WORDS;
        if (i < IDX_WORDS)
            b = tag_byte(i[1:0]);
        else if (i < IDX_PLAYERS)
            b = c.word[wi[4:2]][{wi[1:0], 3'b000} +: 8];
        else if (i == IDX_PLAYERS)
            b = c.player_count;
        else if (i == IDX_SLOT)
            b = c.slot;
        else
            b = 8'd0;
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/handshake_offer_checker.sv
// Top level of the handshake offer checker.
//
// Input stream: one beat per item. s_tuser = 0 is a tick, 1 is a received
// packet byte in s_tdata[7:0]; s_tlast marks the final packet byte and
// s_tdata[8] says the packet came from the expected peer.
// Output stream: m_tuser is the beat kind (offer byte, tick status, packet
// verdict), m_tlast closes the run of beats caused by one item.
// A due tick gives the 28-byte own offer, one beat per cycle while the
// receiver is ready; any other tick and every final packet byte give one
// beat; other packet bytes give none. Path: input register, then result
// register, to m_tvalid. Throughput: one item per cycle with the receiver
// ready, except that an offer holds the input for its 28 beats, set by the
// single offer byte sequencer. Reset clears the handshake to waiting, the
// counters to zero and the config to its defaults. When the receiver stalls,
// the result beat holds, one item more waits in the input register, and
// packet bytes that give no beat keep flowing.
`default_nettype none

module handshake_offer_checker
    import hoc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte[7:0], from_peer[8], zero fill
    input  wire logic        s_tuser,   // cmd
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // tx_byte, consumed, phase, reason,
                                        // offers_sent, forwarded_count, zero fill
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);

    cfg_t      cfg;
    grace_wr_t grace_wr;
    logic      in_valid_reg;
    item_t     item_reg;
    logic      consume;
    logic      out_free;
    logic      beat_valid;
    beat_t     beat;

    hoc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .grace_wr  (grace_wr)
    );

    assign s_tready = !in_valid_reg || consume;
    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.cmd       <= s_tuser;
            item_reg.rx_byte   <= s_tdata[7:0];
            item_reg.rx_last   <= s_tlast;
            item_reg.from_peer <= s_tdata[8];
        end
    end

    hoc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .grace_wr   (grace_wr),
        .item_valid (in_valid_reg),
        .item       (item_reg),
        .out_free   (out_free),
        .consume    (consume),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    hoc_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (beat_valid),
        .beat     (beat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: design/hoc_cfg.sv
// Configuration register file of the handshake offer checker.
`default_nettype none

module hoc_cfg
    import hoc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    output cfg_t             cfg,
    output grace_wr_t        grace_wr
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.word         <= '0;
            cfg_reg.player_count <= PLAYERS_RESET;
            cfg_reg.slot         <= 8'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr)) inside
                REG_PROTOCOL, REG_HASH, REG_STATE_SIZE, REG_INPUT_SIZE, REG_SEED:
                    cfg_reg.word[cfg_addr] <= cfg_wdata;
                REG_PLAYER_COUNT: cfg_reg.player_count <= cfg_wdata[7:0];
                REG_SLOT:         cfg_reg.slot         <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    assign cfg           = cfg_reg;
    assign grace_wr.load  = cfg_we && (cfg_reg_t'(cfg_addr) == REG_GRACE);
    assign grace_wr.value = cfg_wdata[7:0];

endmodule

`default_nettype wire

// File: design/hoc_engine.sv
// Handshake state, received offer checker and own offer sequencer.
`default_nettype none

module hoc_engine
    import hoc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire grace_wr_t  grace_wr,
    input  wire logic       item_valid,
    input  wire item_t      item,
    input  wire logic       out_free,
    output logic            consume,
    output logic            beat_valid,
    output beat_t           beat
);

    phase_t     phase_reg, phase_next;
    reason_t    reason_reg, reason_next;
    logic [7:0] grace_reg, grace_next;
    rx_idx_t    rx_cnt_reg, rx_cnt_next;
    logic       tag_ok_reg, tag_ok_next;
    logic [5:0] mis_reg, mis_next;
    logic [7:0] their_cnt_reg, their_cnt_next;
    logic [7:0] their_slot_reg, their_slot_next;
    count_t     sent_reg, sent_next;
    count_t     fwd_reg, fwd_next;
    logic       busy_reg, busy_next;
    rx_idx_t    idx_reg, idx_next;

    rx_idx_t    rx_i;
    rx_idx_t    rx_wi;
    rx_idx_t    rx_inc;
    logic       pkt_ok;
    logic       due;
    reason_t    cmp;

    always_comb
    begin
        phase_next      = phase_reg;
        reason_next     = reason_reg;
        grace_next      = grace_reg;
        rx_cnt_next     = rx_cnt_reg;
        tag_ok_next     = tag_ok_reg;
        mis_next        = mis_reg;
        their_cnt_next  = their_cnt_reg;
        their_slot_next = their_slot_reg;
        sent_next       = sent_reg;
        fwd_next        = fwd_reg;
        busy_next       = busy_reg;
        idx_next        = idx_reg;

        consume     = 1'b0;
        beat_valid  = 1'b0;
        beat.kind     = KIND_STATUS;
        beat.tx_byte  = 8'd0;
        beat.last     = 1'b1;
        beat.consumed = 1'b0;

        rx_i   = rx_cnt_reg;
        rx_wi  = rx_i - IDX_WORDS;
        rx_inc = (rx_i < RX_SAT) ? rx_i + 5'd1 : rx_i;
        pkt_ok = 1'b0;
        cmp    = RSN_NONE;
        due    = (phase_reg == PH_WAIT) || (phase_reg == PH_AGREED && grace_reg != 8'd0);

        if (busy_reg)
        begin
            if (out_free)
            begin
                beat_valid   = 1'b1;
                beat.kind    = KIND_OFFER;
                beat.tx_byte = offer_byte(cfg, idx_reg);
                beat.last    = (idx_reg == IDX_LAST);
                idx_next     = idx_reg + 5'd1;
                if (idx_reg == IDX_LAST)
                    busy_next = 1'b0;
            end
        end
        else if (item_valid)
        begin
            if (item.cmd == CMD_TICK)
            begin
                if (out_free)
                begin
                    consume    = 1'b1;
                    beat_valid = 1'b1;
                    if (due)
                    begin
                        if (sent_reg != '1)
                            sent_next = sent_reg + 1'b1;
                        if (phase_reg == PH_AGREED)
                            grace_next = grace_reg - 8'd1;
                        busy_next    = 1'b1;
                        idx_next     = 5'd1;
                        beat.kind    = KIND_OFFER;
                        beat.tx_byte = offer_byte(cfg, 5'd0);
                        beat.last    = 1'b0;
                    end
                end
            end
            else if (!item.rx_last || out_free)
            begin
                consume = 1'b1;
                if (rx_i < IDX_WORDS)
                begin
                    if (item.rx_byte != tag_byte(rx_i[1:0]))
                        tag_ok_next = 1'b0;
                end
                else if (rx_i < IDX_PLAYERS)
                begin
                    if (item.rx_byte != offer_byte(cfg, rx_i))
                        mis_next[word_flag(rx_wi[4:2])] = 1'b1;
                end
                else if (rx_i == IDX_PLAYERS)
                begin
                    their_cnt_next = item.rx_byte;
                    if (item.rx_byte != cfg.player_count)
                        mis_next[1] = 1'b1;
                end
                else if (rx_i == IDX_SLOT)
                begin
                    their_slot_next = item.rx_byte;
                end
                rx_cnt_next = rx_inc;

                if (item.rx_last)
                begin
                    pkt_ok = item.from_peer && (rx_inc == OFFER_LEN) && tag_ok_next;
                    if (cfg.slot == their_slot_next)
                        cmp = RSN_SAME_SLOT;
                    else if (cfg.slot >= cfg.player_count || their_slot_next >= their_cnt_next)
                        cmp = RSN_SLOT_RANGE;
                    for (int k = 5; k >= 0; k--)
                    begin
                        if (mis_next[k])
                            cmp = reason_t'(4'(k + 1));
                    end
                    if (pkt_ok)
                    begin
                        if (phase_reg == PH_WAIT)
                        begin
                            reason_next = cmp;
                            phase_next  = (cmp == RSN_NONE) ? PH_AGREED : PH_REFUSED;
                        end
                    end
                    else if (fwd_reg != '1)
                    begin
                        fwd_next = fwd_reg + 1'b1;
                    end
                    rx_cnt_next     = 5'd0;
                    tag_ok_next     = 1'b1;
                    mis_next        = 6'd0;
                    their_cnt_next  = 8'd0;
                    their_slot_next = 8'd0;
                    beat_valid      = 1'b1;
                    beat.kind       = KIND_VERDICT;
                    beat.consumed   = pkt_ok;
                end
            end
        end

        // grace write lands only in the waiting phase
        if (grace_wr.load && phase_reg == PH_WAIT)
            grace_next = grace_wr.value;

        beat.phase  = phase_next;
        beat.reason = reason_next;
        beat.sent   = 16'(sent_next);
        beat.fwd    = 16'(fwd_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            reason_reg     <= RSN_NONE;
            grace_reg      <= GRACE_RESET;
            rx_cnt_reg     <= 5'd0;
            tag_ok_reg     <= 1'b1;
            mis_reg        <= 6'd0;
            their_cnt_reg  <= 8'd0;
            their_slot_reg <= 8'd0;
            sent_reg       <= '0;
            fwd_reg        <= '0;
            busy_reg       <= 1'b0;
            idx_reg        <= 5'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            reason_reg     <= reason_next;
            grace_reg      <= grace_next;
            rx_cnt_reg     <= rx_cnt_next;
            tag_ok_reg     <= tag_ok_next;
            mis_reg        <= mis_next;
            their_cnt_reg  <= their_cnt_next;
            their_slot_reg <= their_slot_next;
            sent_reg       <= sent_next;
            fwd_reg        <= fwd_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hoc_out_reg.sv
// Result register driving the master-side stream.
`default_nettype none

module hoc_out_reg
    import hoc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire beat_t        beat,
    input  wire logic         m_tready,
    output logic              m_tvalid,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic  valid_reg;
    beat_t beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            beat_reg <= beat;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = beat_reg.kind;
    assign m_tlast  = beat_reg.last;
    assign m_tdata  = {1'b0, beat_reg.fwd, beat_reg.sent, beat_reg.reason,
                       beat_reg.phase, beat_reg.consumed, beat_reg.tx_byte};

endmodule

`default_nettype wire

// File: design/hoc_checker.sv
// Port-level checks of the handshake offer checker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module hoc_checker
    import hoc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    logic offer_beat;
    logic other_beat;

    assign offer_beat = m_tvalid && (m_tuser == KIND_OFFER);
    assign other_beat = m_tvalid && (m_tuser != KIND_OFFER);

    `HOC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed while stalled")

    `HOC_ASSERT_NEXT(a_offer_unbroken, offer_beat && m_tready && !m_tlast, !other_beat, "offer run interrupted by another beat")

    `HOC_ASSERT_NOW(a_single_beat_last, other_beat, m_tlast, "status or verdict beat without last")

    `HOC_ASSERT_NOW(a_unused_fields, other_beat, m_tdata[7:0] == 8'd0 && (m_tuser == KIND_VERDICT || !m_tdata[8]), "unused field not zero")

endmodule

bind handshake_offer_checker hoc_checker u_hoc_checker (.*);

`default_nettype wire
